// File: design/rbd_pkg.sv
// Shared types, constants and colour conversion for the run-length bitmap decoder.
package rbd_pkg;

   // Pixel modes as written to the mode register.
   localparam logic [1:0] MODE_INDEXED = 2'd0;
   localparam logic [1:0] MODE_REDUCED = 2'd1;
   localparam logic [1:0] MODE_RGBA    = 2'd2;

   // Register map: one 32-bit register every 4 bytes.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic REG_PIXEL_MODE  = 1'b0;
   localparam logic REG_TRANSPARENT = 1'b1;

   // Record geometry: index of the count byte within a record.
   localparam logic [2:0] PAIR_COUNT_PHASE = 3'd1;
   localparam logic [2:0] RGBA_COUNT_PHASE = 3'd4;
   localparam logic [1:0] HEADER_LAST_PHASE = 2'd3;

   // Opaque marker in the top byte of an RGBA colour.
   localparam logic [7:0] OPAQUE_TAG  = 8'h80;
   localparam logic [7:0] ALPHA_FULL  = 8'hFF;

   typedef enum logic {
      KIND_HEADER = 1'b0,
      KIND_RUN    = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [1:0]  pixel_mode;
      logic [31:0] transparent_colour;
   } cfg_type;

   typedef struct packed {
      result_kind_type result_kind;
      logic [15:0]     image_width;
      logic [15:0]     image_height;
      logic [31:0]     run_start;
      logic [31:0]     run_colour;
      logic [7:0]      run_count;
      logic            overrun;
   } result_type;

   // Colour conversion from the collected record bytes; mode 3 acts as indexed.
   function automatic logic [31:0] convert_colour(input logic [1:0]  mode,
                                                  input logic [31:0] rec,
                                                  input logic [31:0] transp);
      logic [7:0] p;
      logic [31:0] colour;
      p = rec[7:0];
      unique case (mode)
         MODE_RGBA: begin
            if (p != ALPHA_FULL) colour = transp;
            else                 colour = {OPAQUE_TAG, rec[31:8]};
         end
         MODE_REDUCED: begin
            if ({24'd0, p} == transp) colour = transp;
            else                      colour = {27'd0, p[7], p[5:4], p[2:1]};
         end
         default: colour = {24'd0, p};
      endcase
      return colour;
   endfunction

endpackage

// File: design/rbd_csr.sv
// Configuration registers behind the APB-style port.
module rbd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rbd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output rbd_pkg::cfg_type                   cfg
);

   logic [1:0]  mode_ff;
   logic [31:0] transp_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   // Register writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= rbd_pkg::MODE_INDEXED;
         transp_ff <= 32'd0;
      end else if (wr_en) begin
         unique case (paddr[2])
            rbd_pkg::REG_PIXEL_MODE:  mode_ff   <= pwdata[1:0];
            rbd_pkg::REG_TRANSPARENT: transp_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (paddr[2])
         rbd_pkg::REG_PIXEL_MODE:  prdata = {30'd0, mode_ff};
         rbd_pkg::REG_TRANSPARENT: prdata = transp_ff;
         default:                  prdata = 32'd0;
      endcase
   end

   assign cfg.pixel_mode         = mode_ff;
   assign cfg.transparent_colour = transp_ff;

endmodule

// File: design/rbd_rsp_reg.sv
// Result register holding one transaction for the result channel.
module rbd_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rbd_pkg::result_type   load_data,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rbd_pkg::result_type   rsp_data
);

   logic                valid_ff;
   logic                valid_in;
   rbd_pkg::result_type data_ff;

   // Free when empty or being drained this cycle
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

`ifndef SYNTHESIS
   // A held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free) else $error("result register overwritten");
   // A stalled result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(data_ff))
      else $error("stalled result changed");
   // Loads cause a valid result next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff) else $error("loaded result not valid");
`endif

endmodule

// File: design/rbd_core.sv
// Input register, header/record parse state and combinational run decode.
module rbd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  rbd_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_image,
   input  logic                  out_free,
   output logic                  out_load,
   output rbd_pkg::result_type   out_data
);

   // Input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;

   // Parse state
   logic [2:0]  phase_ff, phase_in;
   logic        in_header_ff, in_header_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] rec_ff, rec_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] area_ff;

   logic        has_result;
   logic        s1_adv;
   logic        area_load;
   logic [1:0]  mode;
   logic [2:0]  count_phase;
   logic [15:0] height_full;
   logic [32:0] run_end;

   // Unused mode code falls back to indexed
   assign mode = (cfg.pixel_mode == rbd_pkg::MODE_RGBA)    ? rbd_pkg::MODE_RGBA :
                 (cfg.pixel_mode == rbd_pkg::MODE_REDUCED) ? rbd_pkg::MODE_REDUCED :
                                                             rbd_pkg::MODE_INDEXED;
   assign count_phase = (mode == rbd_pkg::MODE_RGBA) ? rbd_pkg::RGBA_COUNT_PHASE
                                                     : rbd_pkg::PAIR_COUNT_PHASE;

   assign has_result = in_header_ff ? (phase_ff[1:0] == rbd_pkg::HEADER_LAST_PHASE)
                                    : (phase_ff >= count_phase);
   assign s1_adv     = s1_valid_ff && (!has_result || out_free);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign out_load   = s1_adv && has_result;

   assign height_full = {height_ff[15:8], s1_byte_ff};
   assign run_end     = {1'b0, pos_ff} + {25'd0, s1_byte_ff};
   assign area_load   = s1_adv && in_header_ff
                        && (phase_ff[1:0] == rbd_pkg::HEADER_LAST_PHASE);

   // Input register
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_end_of_image;
      end
   end

   // Image area, formed once the last header byte is in
   always_ff @(posedge clock) begin
      if (area_load) area_ff <= {16'd0, width_ff} * {16'd0, height_full};
   end

   // Next parse state and result
   always_comb begin
      phase_in     = phase_ff;
      in_header_in = in_header_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rec_in       = rec_ff;
      pos_in       = pos_ff;

      out_data.result_kind  = rbd_pkg::KIND_RUN;
      out_data.image_width  = width_ff;
      out_data.image_height = height_ff;
      out_data.run_start    = pos_ff;
      out_data.run_colour   = rbd_pkg::convert_colour(mode, rec_ff,
                                                      cfg.transparent_colour);
      out_data.run_count    = s1_byte_ff;
      out_data.overrun      = run_end > {1'b0, area_ff};

      if (in_header_ff) begin
         unique case (phase_ff[1:0])
            2'd0:    width_in  = {s1_byte_ff, width_ff[7:0]};
            2'd1:    width_in  = {width_ff[15:8], s1_byte_ff};
            2'd2:    height_in = {s1_byte_ff, height_ff[7:0]};
            default: height_in = height_full;
         endcase
         if (has_result) begin
            in_header_in = 1'b0;
            phase_in     = 3'd0;
         end else begin
            phase_in = phase_ff + 3'd1;
         end
         out_data.result_kind  = rbd_pkg::KIND_HEADER;
         out_data.image_height = height_full;
         out_data.run_start    = 32'd0;
         out_data.run_colour   = 32'd0;
         out_data.run_count    = 8'd0;
         out_data.overrun      = 1'b0;
      end else if (has_result) begin
         pos_in   = run_end[32] ? 32'hFFFF_FFFF : run_end[31:0];
         phase_in = 3'd0;
         rec_in   = 32'd0;
      end else begin
         rec_in   = {rec_ff[23:0], s1_byte_ff};
         phase_in = phase_ff + 3'd1;
      end

      // End of image returns the parser to its start
      if (s1_last_ff) begin
         phase_in     = 3'd0;
         in_header_in = 1'b1;
         width_in     = 16'd0;
         height_in    = 16'd0;
         rec_in       = 32'd0;
         pos_in       = 32'd0;
      end
   end

   // State register, updated as each transaction leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 3'd0;
         in_header_ff <= 1'b1;
         width_ff     <= 16'd0;
         height_ff    <= 16'd0;
         rec_ff       <= 32'd0;
         pos_ff       <= 32'd0;
      end else if (s1_adv) begin
         phase_ff     <= phase_in;
         in_header_ff <= in_header_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rec_ff       <= rec_in;
         pos_ff       <= pos_in;
      end
   end

`ifndef SYNTHESIS
   // Header phase never passes its fourth byte
   a_header_phase: assert property (@(posedge clock) disable iff (reset)
      in_header_ff |-> phase_ff <= 3'd3) else $error("header phase out of range");
   // Record phase never passes the RGBA count byte
   a_record_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= rbd_pkg::RGBA_COUNT_PHASE) else $error("record phase out of range");
   // Completing the header leaves header mode unless the image ends there
   a_header_done: assert property (@(posedge clock) disable iff (reset)
      area_load && !s1_last_ff |=> !in_header_ff)
      else $error("header did not complete");
   // End of image restarts the parser
   a_restart: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_last_ff |=> in_header_ff && phase_ff == 3'd0 && pos_ff == 32'd0)
      else $error("end of image did not restart");
`endif

endmodule

// File: design/rle_bitmap_run_decoder_unit.sv
// Top level of the run-length bitmap decoder.
// Accepts one encoded byte per cycle, with no gaps between images, unless
// stalled as described below. Each byte is held in the input register, where
// a single decode step (header byte capture or record collection, colour
// conversion, run end add and overrun compare) runs, and the result then
// lands in the output register, from which it is offered on the result
// channel. The fourth header byte gives a header result and the last byte of
// each record gives a run command; other bytes give none. The image area is
// multiplied out once per image, as the last header byte passes. Backpressure
// on the result channel stalls input only when a byte that completes a result
// finds the output register full.
module rle_bitmap_run_decoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_end_of_image,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_result_kind,
   output logic [15:0]                       rsp_image_width,
   output logic [15:0]                       rsp_image_height,
   output logic [31:0]                       rsp_run_start,
   output logic [31:0]                       rsp_run_colour,
   output logic [7:0]                        rsp_run_count,
   output logic                              rsp_overrun,
   // Configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rbd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   rbd_pkg::cfg_type    cfg;
   rbd_pkg::result_type core_data;
   rbd_pkg::result_type rsp_data;
   logic                out_free;
   logic                out_load;

   rbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rbd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_image (req_end_of_image),
      .out_free         (out_free),
      .out_load         (out_load),
      .out_data         (core_data)
   );

   rbd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (core_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_result_kind  = rsp_data.result_kind;
   assign rsp_image_width  = rsp_data.image_width;
   assign rsp_image_height = rsp_data.image_height;
   assign rsp_run_start    = rsp_data.run_start;
   assign rsp_run_colour   = rsp_data.run_colour;
   assign rsp_run_count    = rsp_data.run_count;
   assign rsp_overrun      = rsp_data.overrun;

endmodule
